// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/core/swrbv_pkg.sv -----
// shared constants and types of the stack with remove by value
// no dependencies; imported by the controller, the top level and the checker
`default_nettype none

package swrbv_pkg;

  localparam int DEPTH     = 64;
  localparam int ADDR_W    = 6;
  localparam int CNT_W     = 7;
  localparam int DATA_W    = 32;
  localparam int MDEPTH_W  = 6;
  localparam int STATUS_W  = 2;
  localparam int OUT_TDATA_W = 16;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // operation codes
  localparam logic FUNC_PUSH   = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // memory access from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/swrbv_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module swrbv_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/swrbv_ctrl.sv -----
// sequencer: entry count, push, top-down scan and gap-closing shift
// depends on swrbv_pkg; drives the stack ram through mem_req_t
`default_nettype none

module swrbv_ctrl
  import swrbv_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic                s_func,
  input  wire logic [DATA_W-1:0]   s_value,
  input  wire logic [CNT_W-1:0]    capacity,
  input  wire logic                out_free,
  output logic                     res_load,
  output logic [STATUS_W-1:0]      res_status,
  output logic [CNT_W-1:0]         res_count,
  output logic [MDEPTH_W-1:0]      res_depth,
  output mem_req_t                 mem_req,
  input  wire logic [DATA_W-1:0]   rd_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]          state;
  logic [CNT_W-1:0]    count;
  logic [DATA_W-1:0]   key;
  logic [ADDR_W-1:0]   ptr;
  logic [ADDR_W-1:0]   wptr;
  logic [ADDR_W-1:0]   rptr;
  logic                primed;
  logic [STATUS_W-1:0] status_r;
  logic [MDEPTH_W-1:0] depth_r;

  logic             accept;
  logic             is_full;
  logic             push_ok;
  logic             hit;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_p1;
  logic [CNT_W-1:0] match_above;

  // request decode
  assign s_tready    = (state == S_IDLE) && out_free;
  assign accept      = s_tvalid && s_tready;
  assign is_full     = (count >= capacity) || (count >= CNT_W'(DEPTH));
  assign push_ok     = accept && (s_func == FUNC_PUSH) && !is_full;
  assign hit         = (rd_data == key);
  assign cnt_m1      = count - CNT_W'(1);
  assign cnt_p1      = count + CNT_W'(1);
  assign match_above = cnt_m1 - {1'b0, ptr};

  // memory requests; in the shift the write trails the read by two entries
  always_comb begin
    mem_req.we    = push_ok || ((state == S_SHIFT) && primed);
    mem_req.waddr = (state == S_SHIFT) ? wptr : count[ADDR_W-1:0];
    mem_req.wdata = (state == S_SHIFT) ? rd_data : s_value;
    unique case (state)
      S_IDLE:  mem_req.raddr = cnt_m1[ADDR_W-1:0];
      S_SCAN:  mem_req.raddr = ptr - ADDR_W'(1);
      S_SHIFT: mem_req.raddr = rptr;
      default: mem_req.raddr = ptr;
    endcase
  end

  // result to the output register
  always_comb begin
    res_load = (accept && ((s_func == FUNC_PUSH) || (count == '0)))
            || ((state == S_FINISH) && out_free);
    if (state == S_FINISH) begin
      res_status = status_r;
      res_count  = count;
      res_depth  = depth_r;
    end else if (s_func == FUNC_PUSH) begin
      res_status = is_full ? ST_FULL : ST_OK;
      res_count  = is_full ? count : cnt_p1;
      res_depth  = '0;
    end else begin
      res_status = ST_EMPTY;
      res_count  = count;
      res_depth  = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      primed <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (push_ok) begin
            count <= cnt_p1;
          end else if (accept && (s_func == FUNC_REMOVE) && (count != '0)) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            if ({1'b0, ptr} == cnt_m1) begin
              count <= cnt_m1;
              state <= S_FINISH;
            end else begin
              primed <= 1'b0;
              state  <= S_SHIFT;
            end
          end else if (ptr == '0) begin
            state <= S_FINISH;
          end
        end
        S_SHIFT: begin
          primed <= 1'b1;
          if (primed && (({1'b0, wptr} + CNT_W'(2)) == count)) begin
            count  <= cnt_m1;
            primed <= 1'b0;
            state  <= S_FINISH;
          end
        end
        default: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // scan and shift pointers, search key, pending result
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        key <= s_value;
        ptr <= cnt_m1[ADDR_W-1:0];
      end
      S_SCAN: begin
        if (hit) begin
          status_r <= ST_OK;
          depth_r  <= match_above[MDEPTH_W-1:0];
          wptr     <= ptr;
          rptr     <= ptr + ADDR_W'(1);
        end else begin
          status_r <= ST_NOT_FOUND;
          depth_r  <= '0;
          ptr      <= ptr - ADDR_W'(1);
        end
      end
      S_SHIFT: begin
        rptr <= rptr + ADDR_W'(1);
        if (primed) begin
          wptr <= wptr + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/stack_with_remove_by_value.sv -----
// Bounded stack of signed 32-bit words with push and remove-by-value.
// Request items enter on the s_ stream: s_tdata carries the word, s_tuser
// the operation (push or remove the topmost equal entry). Each request gives
// exactly one result item on the m_ stream: m_tuser is the status (ok, full,
// empty, not found), m_tdata the entry count and the match depth.
// The capacity register is written through cfg_valid/cfg_data, always ready;
// write it only while no request is in flight. Values above 64 act as 64.
// A push, or a remove on an empty stack, gives its result in the cycle
// after the item is accepted. A remove scans the ram from the top down, one
// entry a cycle, then moves the entries above the match down one a cycle.
// The single read port of the ram is why both steps go one entry at a time.
// A finished result waits in the output register; while it is stalled by
// m_tready no new request is accepted.
// Reset empties the stack and sets the capacity to 64; the ram is not cleared.
// depends on swrbv_pkg, swrbv_ctrl and swrbv_ram
`default_nettype none

module stack_with_remove_by_value
  import swrbv_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // request: [31:0] value
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [DATA_W-1:0]      s_tdata,
  // request: [0] func
  input  wire logic                   s_tuser,
  // result: [6:0] entry_count, [12:7] match_depth, zeros above
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // result: [1:0] status
  output logic [STATUS_W-1:0]         m_tuser,
  // capacity register write
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CNT_W-1:0]       cfg_data
);

  logic [CNT_W-1:0]    capacity;
  logic                out_free;
  logic                res_load;
  logic [STATUS_W-1:0] res_status;
  logic [CNT_W-1:0]    res_count;
  logic [MDEPTH_W-1:0] res_depth;
  mem_req_t            mem_req;
  logic [DATA_W-1:0]   rd_data;

  // capacity register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // output register
  assign out_free = !m_tvalid || m_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tuser <= res_status;
      m_tdata <= {(OUT_TDATA_W - CNT_W - MDEPTH_W)'(0), res_depth, res_count};
    end
  end

  swrbv_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_func     (s_tuser),
    .s_value    (s_tdata),
    .capacity   (capacity),
    .out_free   (out_free),
    .res_load   (res_load),
    .res_status (res_status),
    .res_count  (res_count),
    .res_depth  (res_depth),
    .mem_req    (mem_req),
    .rd_data    (rd_data)
  );

  swrbv_ram #(
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

endmodule

`default_nettype wire

// ----- rtl/core/swrbv_checker.sv -----
// port-level checks of the stack with remove by value, bound to the top level
// depends on swrbv_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module swrbv_checker
  import swrbv_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic [STATUS_W-1:0]    m_tuser
);

  // a stalled result item stays and holds its payload
  `ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

  // the count never passes the stack depth
  `ASSERT_IMPLIES(a_count_max, clk, rst, m_tvalid, m_tdata[6:0] <= 7'd64)

  // match depth only with an ok status, and never above the remaining count
  `ASSERT_IMPLIES(a_depth_ok, clk, rst, m_tvalid && (m_tuser != ST_OK), m_tdata[12:7] == 6'd0)
  `ASSERT_IMPLIES(a_depth_max, clk, rst, m_tvalid, {1'b0, m_tdata[12:7]} <= m_tdata[6:0])

endmodule

bind stack_with_remove_by_value swrbv_checker u_swrbv_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
